### rtl/pmfd_pkg.sv
// ----------------------------------------------------------------------------
// pmfd_pkg
// Shared types and constants of the power meter frame decoder.
// ----------------------------------------------------------------------------
package pmfd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'h5A;

  localparam int POS_W  = 5;   // frame position, frames of up to 32 bytes
  localparam int FLD_W  = 24;  // one metering field
  localparam int DIV_W  = 34;  // dividend and quotient width
  localparam int OPA_W  = 40;  // multiplicand / divisor operand width
  localparam int ACC_W  = 54;  // product / remainder register width
  localparam int STEP_W = 6;   // iteration count

  localparam logic [STEP_W-1:0] DIV_STEPS  = 6'd34;
  localparam logic [STEP_W-1:0] PMUL_STEPS = 6'd16;
  localparam logic [STEP_W-1:0] EMUL_STEPS = 6'd14;

  // configuration register indexes
  localparam logic [2:0] REG_VOLT_MAX = 3'd0;
  localparam logic [2:0] REG_VOLT_MIN = 3'd1;
  localparam logic [2:0] REG_CUR_MAX  = 3'd2;
  localparam logic [2:0] REG_PERIOD   = 3'd3;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } pmfd_op_t;

  typedef struct packed {
    pmfd_op_t          op;
    logic [STEP_W-1:0] steps;
    logic [OPA_W-1:0]  opa;   // multiplicand, or divisor in the low bits
    logic [DIV_W-1:0]  opb;   // multiplier left aligned, or dividend
  } pmfd_alu_req_t;

  typedef struct packed {
    logic [FLD_W-1:0] volt_param;
    logic [FLD_W-1:0] volt_reg;
    logic [FLD_W-1:0] curr_param;
    logic [FLD_W-1:0] curr_reg;
  } pmfd_fields_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VDIV,
    ST_VWAIT,
    ST_CDIV,
    ST_CWAIT,
    ST_PMUL,
    ST_PWAIT,
    ST_EMUL,
    ST_EWAIT,
    ST_EMIT
  } pmfd_state_t;

endpackage

### rtl/pmfd_alu.sv
// ----------------------------------------------------------------------------
// pmfd_alu
// Shared one-bit-per-cycle unit: restoring divide or shift-add multiply.
// ----------------------------------------------------------------------------
module pmfd_alu (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  pmfd_pkg::pmfd_alu_req_t       req,
  output logic                          done,
  output logic [pmfd_pkg::DIV_W-1:0]    quot,
  output logic [pmfd_pkg::ACC_W-1:0]    prod
);
  import pmfd_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] cnt;
  pmfd_op_t          op;
  logic [ACC_W-1:0]  acc;
  logic [OPA_W-1:0]  opx;
  logic [DIV_W-1:0]  sh;

  logic [FLD_W:0]    rem_sh;
  logic [ACC_W-1:0]  add_a;
  logic [ACC_W-1:0]  add_b;
  logic              cin;
  logic [ACC_W:0]    sum;

  // single adder: accumulate for multiply, trial subtract for divide
  always_comb begin
    rem_sh = {acc[FLD_W-1:0], sh[DIV_W-1]};
    if (op == OP_MUL) begin
      add_a = {acc[ACC_W-2:0], 1'b0};
      add_b = sh[DIV_W-1] ? {{(ACC_W-OPA_W){1'b0}}, opx} : '0;
      cin   = 1'b0;
    end else begin
      add_a = {{(ACC_W-FLD_W-1){1'b0}}, rem_sh};
      add_b = ~{{(ACC_W-FLD_W){1'b0}}, opx[FLD_W-1:0]};
      cin   = 1'b1;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {{ACC_W{1'b0}}, cin};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op  <= req.op;
      acc <= '0;
      opx <= req.opa;
      sh  <= req.opb;
    end else if (busy) begin
      if (op == OP_MUL) begin
        acc <= sum[ACC_W-1:0];
        sh  <= {sh[DIV_W-2:0], 1'b0};
      end else begin
        // carry out set means the divisor fits: keep the difference
        acc <= sum[ACC_W] ? sum[ACC_W-1:0] : {{(ACC_W-FLD_W-1){1'b0}}, rem_sh};
        sh  <= {sh[DIV_W-2:0], sum[ACC_W]};
      end
    end
  end

  assign quot = sh;
  assign prod = acc;

endmodule

### rtl/pmfd_frame.sv
// ----------------------------------------------------------------------------
// pmfd_frame
// Sync hunt and byte collection of one metering frame.
// ----------------------------------------------------------------------------
module pmfd_frame #(
  parameter int FRAME_BYTES = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_en,
  input  logic [7:0]             rx_byte,
  output pmfd_pkg::pmfd_fields_t fields,
  output logic                   frame_end
);
  import pmfd_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0] pos;

  assign frame_end = byte_en && (pos > POS_W'(1)) && (pos == LAST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      fields <= '0;
    end else if (byte_en) begin
      case (pos)
        POS_W'(0): pos <= (rx_byte == SYNC_FIRST) ? POS_W'(1) : POS_W'(0);
        POS_W'(1): begin
          if (rx_byte == SYNC_SECOND) begin
            pos <= POS_W'(2);
          end else begin
            pos <= (rx_byte == SYNC_FIRST) ? POS_W'(1) : POS_W'(0);
          end
        end
        default: begin
          // shift big-endian fields in; bytes past the fourth field are dropped
          if (pos <= POS_W'(4)) begin
            fields.volt_param <= {fields.volt_param[FLD_W-9:0], rx_byte};
          end else if (pos <= POS_W'(7)) begin
            fields.volt_reg <= {fields.volt_reg[FLD_W-9:0], rx_byte};
          end else if (pos <= POS_W'(10)) begin
            fields.curr_param <= {fields.curr_param[FLD_W-9:0], rx_byte};
          end else if (pos <= POS_W'(13)) begin
            fields.curr_reg <= {fields.curr_reg[FLD_W-9:0], rx_byte};
          end
          pos <= (pos == LAST_POS) ? '0 : pos + 1'b1;
        end
      endcase
    end
  end

endmodule

### rtl/power_meter_frame_decoder.sv
// ----------------------------------------------------------------------------
// power_meter_frame_decoder
// Metering link frame decoder with voltage, current, power and energy.
// ----------------------------------------------------------------------------
// Feed the meter's UART bytes in one word each (tuser low) or a clear
// command (tuser high) that zeroes the energy total. Each byte that does not
// close a frame is taken at once while the block is idle. The closing byte
// starts a sequence on one shared shift/add unit that works one bit a cycle:
// a 34-step voltage divide, a 34-step current divide, a 16-step power
// multiply and a 14-step energy multiply. Each is issued from its own state
// and waited for in a wait state, and an emit state loads the output register
// once it is free, so an earlier result word still waiting there holds the
// sequence; s_tready is low all that time. A zero divisor or zero voltage
// skips the steps that no longer matter. The result word waits in an output
// register, so bytes keep flowing while it is not yet taken. There is no
// clearing pass after reset. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module power_meter_frame_decoder #(
  parameter int FRAME_BYTES = 24
) (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] rx_byte
  input  logic [0:0]   s_tuser,   // [0] cmd
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // [15:0] voltage, [39:16] current_ma,
                                  // [79:40] power_mw, [131:80] energy_uj, pad
  output logic [1:0]   m_tuser,   // [0] relay_off, [1] zero_divisor
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);
  import pmfd_pkg::*;

  pmfd_state_t   state, state_next;
  pmfd_fields_t  fields;
  pmfd_alu_req_t alu_req;
  logic          alu_start;
  logic          alu_done;
  logic [DIV_W-1:0] alu_quot;
  logic [ACC_W-1:0] alu_prod;

  logic        in_acc;
  logic        byte_en;
  logic        clr_en;
  logic        frame_end;

  // configuration
  logic [15:0] volt_max;
  logic [15:0] volt_min;
  logic [23:0] cur_max;
  logic [13:0] period_ms;

  // working values of the frame in flight
  logic [15:0] volt;
  logic [23:0] cur;
  logic [39:0] pw;
  logic [ACC_W-1:0] eprod;
  logic        zdiv;
  logic [51:0] energy;

  logic [DIV_W-1:0] cur_dividend;
  logic [ACC_W:0]   e_sum;
  logic [51:0]      energy_next;
  logic             relay;
  logic             out_free;

  assign in_acc   = s_tvalid && s_tready;
  assign byte_en  = in_acc && !s_tuser[0];
  assign clr_en   = in_acc && s_tuser[0];
  assign s_tready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free = !m_tvalid || m_tready;

  // current parameter times 1000 as shifts: 1024 - 16 - 8
  assign cur_dividend = ({10'b0, fields.curr_param} << 10)
                      - ({10'b0, fields.curr_param} << 4)
                      - ({10'b0, fields.curr_param} << 3);

  // saturating energy step
  assign e_sum = {3'b0, energy} + {1'b0, eprod};
  assign energy_next = (e_sum[ACC_W:52] != '0) ? '1 : e_sum[51:0];

  assign relay = (volt != '0) &&
                 ((volt >= volt_max) || (volt <= volt_min) || (cur >= cur_max));

  pmfd_frame #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .byte_en   (byte_en),
    .rx_byte   (s_tdata),
    .fields    (fields),
    .frame_end (frame_end)
  );

  pmfd_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .req   (alu_req),
    .done  (alu_done),
    .quot  (alu_quot),
    .prod  (alu_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: issue each step to the shared unit, skip what a zero makes moot
  always_comb begin
    state_next = state;
    alu_start  = 1'b0;
    alu_req    = '{op: OP_DIV, steps: DIV_STEPS, opa: '0, opb: '0};
    case (state)
      ST_IDLE: begin
        if (frame_end) state_next = ST_VDIV;
      end
      ST_VDIV: begin
        if (fields.volt_reg == '0) begin
          state_next = ST_CDIV;
        end else begin
          alu_start  = 1'b1;
          alu_req    = '{op: OP_DIV, steps: DIV_STEPS,
                         opa: {16'b0, fields.volt_reg},
                         opb: {10'b0, fields.volt_param}};
          state_next = ST_VWAIT;
        end
      end
      ST_VWAIT: begin
        if (alu_done) state_next = ST_CDIV;
      end
      ST_CDIV: begin
        if (volt == '0) begin
          state_next = ST_EMIT;
        end else if (fields.curr_reg == '0) begin
          state_next = ST_PMUL;
        end else begin
          alu_start  = 1'b1;
          alu_req    = '{op: OP_DIV, steps: DIV_STEPS,
                         opa: {16'b0, fields.curr_reg}, opb: cur_dividend};
          state_next = ST_CWAIT;
        end
      end
      ST_CWAIT: begin
        if (alu_done) state_next = ST_PMUL;
      end
      ST_PMUL: begin
        alu_start  = 1'b1;
        alu_req    = '{op: OP_MUL, steps: PMUL_STEPS,
                       opa: {16'b0, cur}, opb: {volt, 18'b0}};
        state_next = ST_PWAIT;
      end
      ST_PWAIT: begin
        if (alu_done) state_next = ST_EMUL;
      end
      ST_EMUL: begin
        alu_start  = 1'b1;
        alu_req    = '{op: OP_MUL, steps: EMUL_STEPS,
                       opa: pw, opb: {period_ms, 20'b0}};
        state_next = ST_EWAIT;
      end
      ST_EWAIT: begin
        if (alu_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      volt_max  <= 16'd250;
      volt_min  <= 16'd180;
      cur_max   <= 24'd10000;
      period_ms <= 14'd250;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VOLT_MAX: volt_max  <= cfg_data[15:0];
        REG_VOLT_MIN: volt_min  <= cfg_data[15:0];
        REG_CUR_MAX:  cur_max   <= cfg_data;
        REG_PERIOD:   period_ms <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // working values
  always_ff @(posedge clk) begin
    case (state)
      ST_VDIV: begin
        zdiv  <= (fields.volt_reg == '0);
        volt  <= '0;
        cur   <= '0;
        pw    <= '0;
        eprod <= '0;
      end
      ST_VWAIT: begin
        if (alu_done) volt <= (alu_quot[DIV_W-1:16] != '0) ? '1 : alu_quot[15:0];
      end
      ST_CDIV: begin
        if (fields.curr_reg == '0) zdiv <= 1'b1;
      end
      ST_CWAIT: begin
        if (alu_done) cur <= (alu_quot[DIV_W-1:24] != '0) ? '1 : alu_quot[23:0];
      end
      ST_PWAIT: begin
        if (alu_done) pw <= alu_prod[39:0];
      end
      ST_EWAIT: begin
        if (alu_done) eprod <= alu_prod;
      end
      default: ;
    endcase
  end

  // energy total: clear on command, advance at frame emit
  always_ff @(posedge clk) begin
    if (rst) begin
      energy <= '0;
    end else if (clr_en) begin
      energy <= '0;
    end else if (state == ST_EMIT && out_free && volt != '0) begin
      energy <= energy_next;
    end
  end

  // output register: load when the slot is free, hold otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_tdata <= {4'b0, ((volt != '0) ? energy_next : energy), pw, cur, volt};
      m_tuser <= {zdiv, relay};
    end
  end

  // assertions
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> (state == ST_VWAIT || state == ST_CWAIT ||
                  state == ST_PWAIT || state == ST_EWAIT))
    else $error("shared unit finished outside a wait state");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    frame_end |=> (state == ST_VDIV))
    else $error("frame end did not start the sequence");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    clr_en |=> (energy == '0))
    else $error("clear command left energy nonzero");

  a_relay_volt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((!m_tuser[0] && m_tdata[39:16] == '0) || m_tdata[15:0] != '0))
    else $error("relay or current reported with zero voltage");

endmodule
